// ----- design/ppfq_pkg.sv -----
package ppfq_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned NrmW   = 16;
  localparam int unsigned DeltaW = PosW + 1;
  localparam int unsigned SqW    = 2 * DeltaW;      // sum of three squares fits 50 bits
  localparam int unsigned DistW  = SqW / 2;
  localparam int unsigned DotW   = 42;              // normal dot delta, signed
  localparam int unsigned NdotW  = 34;              // normal dot normal, signed
  localparam int unsigned CosW   = 16;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned AngW   = 15;
  localparam int unsigned DstW   = 24;

  localparam logic signed [CosW-1:0] CosLimit     = 16'sd16384;
  localparam logic [KeyW-1:0]        KeyDistMax   = 16'hFFFF;
  localparam logic [AngW-1:0]        AngleStepRst = 15'd1638;
  localparam logic [DstW-1:0]        DistStepRst  = 24'd4096;

  // register index, taken from paddr[2]
  localparam logic RegAngleStep = 1'b0;
  localparam logic RegDistStep  = 1'b1;

  typedef struct packed {
    logic signed [PosW-1:0] ref_x;
    logic signed [PosW-1:0] ref_y;
    logic signed [PosW-1:0] ref_z;
    logic signed [NrmW-1:0] ref_nx;
    logic signed [NrmW-1:0] ref_ny;
    logic signed [NrmW-1:0] ref_nz;
    logic signed [PosW-1:0] tgt_x;
    logic signed [PosW-1:0] tgt_y;
    logic signed [PosW-1:0] tgt_z;
    logic signed [NrmW-1:0] tgt_nx;
    logic signed [NrmW-1:0] tgt_ny;
    logic signed [NrmW-1:0] tgt_nz;
  } ppf_req_t;

  typedef struct packed {
    logic signed [CosW-1:0] cos_ref_dir;
    logic signed [CosW-1:0] cos_tgt_dir;
    logic signed [CosW-1:0] cos_normals;
    logic [DistW-1:0]       pair_distance;
    logic signed [KeyW-1:0] key_ref_dir;
    logic signed [KeyW-1:0] key_tgt_dir;
    logic signed [KeyW-1:0] key_normals;
    logic [KeyW-1:0]        key_distance;
    logic                   degenerate;
  } ppf_res_t;

endpackage

// ----- design/ppfq_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Caller keeps the quotient below 2**QW.
module ppfq_udiv #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);

  localparam int unsigned CW = NW + DW + QW;

  logic [QW:0]   v_q;
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quot_q [QW+1];
  logic [TW-1:0] tag_q  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    den_q[0]  <= den_i;
    quot_q[0] <= '0;
    tag_q[0]  <= tag_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - s;
    logic [CW-1:0] trial;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quot_d;

    assign trial  = CW'(den_q[s]) << Bit;
    assign ge     = CW'(rem_q[s]) >= trial;
    assign rem_d  = ge ? NW'(CW'(rem_q[s]) - trial) : rem_q[s];
    assign quot_d = quot_q[s] | (QW'(ge) << Bit);

    always_ff @(posedge clk_i) begin
      quot_q[s+1] <= quot_d;
      tag_q[s+1]  <= tag_q[s];
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = quot_q[QW];
  assign tag_o   = tag_q[QW];

endmodule

// ----- design/ppfq_isqrt.sv -----
// Pipelined floor square root, one root bit per stage.
module ppfq_isqrt #(
  parameter int unsigned XW = 50,
  parameter int unsigned TW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [XW-1:0]      x_i,
  input  logic [TW-1:0]      tag_i,
  output logic               valid_o,
  output logic [XW/2-1:0]    root_o,
  output logic [TW-1:0]      tag_o
);

  localparam int unsigned RW = XW / 2;
  localparam int unsigned AW = XW + 1;

  logic [RW:0]   v_q;
  logic [XW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW+1];
  logic [TW-1:0] tag_q  [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[RW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= x_i;
    root_q[0] <= '0;
    tag_q[0]  <= tag_i;
  end

  // rem holds x - root^2; setting bit i adds (root << (i+1)) + 4**i
  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int unsigned Bit = RW - 1 - s;
    logic [AW-1:0] trial;
    logic          ge;
    logic [XW-1:0] rem_d;
    logic [RW-1:0] root_d;

    assign trial  = (AW'(root_q[s]) << (Bit + 1)) + (AW'(1) << (2 * Bit));
    assign ge     = AW'(rem_q[s]) >= trial;
    assign rem_d  = ge ? XW'(AW'(rem_q[s]) - trial) : rem_q[s];
    assign root_d = root_q[s] | (RW'(ge) << Bit);

    always_ff @(posedge clk_i) begin
      root_q[s+1] <= root_d;
      tag_q[s+1]  <= tag_q[s];
    end

    if (s < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= rem_d;
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = root_q[RW];
  assign tag_o   = tag_q[RW];

endmodule

// ----- design/point_pair_feature_quantizer.sv -----
// Channel   | Direction | Signals                                   | Handshake
// request   | in        | req_i (ppf_req_t)                         | start_i & !busy_o
// result    | out       | res_o (ppf_res_t)                         | done_o, one cycle
// config    | in/out    | psel, penable, pwrite, paddr, pwdata, ... | APB, pready always 1
//
// Fully pipelined: one request per cycle, busy_o is always low.
// A request passes 4 front stages, the square root, the two divider ranks
// (cosine/distance, then keys) and 1 output register.
// Async active-low reset clears the stage valid bits and loads the step registers with their reset values.
// The receiver cannot stall, so no stage ever holds.
module point_pair_feature_quantizer
  import ppfq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  ppf_req_t    req_i,
  output logic        done_o,
  output ppf_res_t    res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [AngW-1:0] angle_step_q;
  logic [DstW-1:0] dist_step_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_step_q <= AngleStepRst;
      dist_step_q  <= DistStepRst;
    end else if (cfg_we) begin
      unique case (paddr[2])
        RegAngleStep: angle_step_q <= pwdata[AngW-1:0];
        RegDistStep:  dist_step_q  <= pwdata[DstW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegAngleStep: prdata = 32'(angle_step_q);
      RegDistStep:  prdata = 32'(dist_step_q);
      default:      prdata = '0;
    endcase
  end

  // zero steps act as one
  logic [AngW-1:0] astep;
  logic [DstW-1:0] dstep;
  assign astep = (angle_step_q == '0) ? AngW'(1) : angle_step_q;
  assign dstep = (dist_step_q == '0) ? DstW'(1) : dist_step_q;

  assign busy_o = 1'b0;

  // ---------------- stage A: request register ----------------
  logic     va_q;
  ppf_req_t req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
  end

  // ---------------- stage B: deltas ----------------
  logic                     vb_q;
  logic signed [DeltaW-1:0] dx_q, dy_q, dz_q;
  logic signed [NrmW-1:0]   n1x_q, n1y_q, n1z_q, n2x_q, n2y_q, n2z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= DeltaW'(req_q.tgt_x) - DeltaW'(req_q.ref_x);
    dy_q  <= DeltaW'(req_q.tgt_y) - DeltaW'(req_q.ref_y);
    dz_q  <= DeltaW'(req_q.tgt_z) - DeltaW'(req_q.ref_z);
    n1x_q <= req_q.ref_nx;
    n1y_q <= req_q.ref_ny;
    n1z_q <= req_q.ref_nz;
    n2x_q <= req_q.tgt_nx;
    n2y_q <= req_q.tgt_ny;
    n2z_q <= req_q.tgt_nz;
  end

  // ---------------- stage C: products ----------------
  localparam int unsigned NdW = NrmW + DeltaW;  // normal times delta
  localparam int unsigned NnW = 2 * NrmW;       // normal times normal

  logic                  vc_q, degen_c_q;
  logic signed [SqW-1:0] sqx_q, sqy_q, sqz_q;
  logic signed [NdW-1:0] p1x_q, p1y_q, p1z_q, p2x_q, p2y_q, p2z_q;
  logic signed [NnW-1:0] nnx_q, nny_q, nnz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    degen_c_q <= (dx_q == '0) && (dy_q == '0) && (dz_q == '0);
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    sqz_q <= dz_q * dz_q;
    p1x_q <= NdW'(n1x_q) * NdW'(dx_q);
    p1y_q <= NdW'(n1y_q) * NdW'(dy_q);
    p1z_q <= NdW'(n1z_q) * NdW'(dz_q);
    p2x_q <= NdW'(n2x_q) * NdW'(dx_q);
    p2y_q <= NdW'(n2y_q) * NdW'(dy_q);
    p2z_q <= NdW'(n2z_q) * NdW'(dz_q);
    nnx_q <= NnW'(n1x_q) * NnW'(n2x_q);
    nny_q <= NnW'(n1y_q) * NnW'(n2y_q);
    nnz_q <= NnW'(n1z_q) * NnW'(n2z_q);
  end

  // ---------------- stage D: sums ----------------
  typedef struct packed {
    logic signed [DotW-1:0]  dot1;
    logic signed [DotW-1:0]  dot2;
    logic signed [NdotW-1:0] dot3;
    logic                    degen;
  } sq_tag_t;

  logic           vd_q;
  logic [SqW-1:0] sq_q;
  sq_tag_t        sqt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q        <= SqW'(sqx_q) + SqW'(sqy_q) + SqW'(sqz_q);
    sqt_q.dot1  <= DotW'(p1x_q) + DotW'(p1y_q) + DotW'(p1z_q);
    sqt_q.dot2  <= DotW'(p2x_q) + DotW'(p2y_q) + DotW'(p2z_q);
    sqt_q.dot3  <= NdotW'(nnx_q) + NdotW'(nny_q) + NdotW'(nnz_q);
    sqt_q.degen <= degen_c_q;
  end

  // ---------------- square root ----------------
  logic             vs;
  logic [DistW-1:0] dist_s;
  sq_tag_t          sqt_s;

  ppfq_isqrt #(
    .XW (SqW),
    .TW ($bits(sq_tag_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q),
    .x_i     (sq_q),
    .tag_i   (sqt_q),
    .valid_o (vs),
    .root_o  (dist_s),
    .tag_o   (sqt_s)
  );

  // ---------------- divider setup ----------------
  // Cosines: |dot| / dist with truncation toward zero. A quotient of 2**16
  // or more saturates anyway, so it is flagged here and the divider gets 0.
  localparam int unsigned QW  = 16;
  localparam int unsigned CmW = DotW + QW;

  typedef struct packed {
    logic                    neg1;
    logic                    ovf1;
    logic                    ovf2;
    logic signed [CosW-1:0]  c3;
    logic [DistW-1:0]        dist_val;
    logic                    degen;
  } cos_tag_t;

  logic [DotW-1:0]          mag1, mag2, num1, num2;
  logic                     neg2, ovfd;
  logic [DistW-1:0]         numd;
  logic signed [NdotW-1:0]  dot3_sh;
  logic signed [CosW-1:0]   c3_s;
  cos_tag_t                 ct_s;

  assign mag1 = sqt_s.dot1[DotW-1] ? DotW'(-sqt_s.dot1) : DotW'(sqt_s.dot1);
  assign mag2 = sqt_s.dot2[DotW-1] ? DotW'(-sqt_s.dot2) : DotW'(sqt_s.dot2);
  assign neg2 = sqt_s.dot2[DotW-1];

  assign ct_s.neg1     = sqt_s.dot1[DotW-1];
  assign ct_s.ovf1     = CmW'(mag1) >= (CmW'(dist_s) << QW);
  assign ct_s.ovf2     = CmW'(mag2) >= (CmW'(dist_s) << QW);
  assign ct_s.c3       = c3_s;
  assign ct_s.dist_val = dist_s;
  assign ct_s.degen    = sqt_s.degen;

  assign num1 = ct_s.ovf1 ? '0 : mag1;
  assign num2 = ct_s.ovf2 ? '0 : mag2;

  // normals cosine: floor shift by 14, then clamp
  assign dot3_sh = sqt_s.dot3 >>> 14;
  always_comb begin
    priority if (dot3_sh > NdotW'(CosLimit)) begin
      c3_s = CosLimit;
    end else if (dot3_sh < -NdotW'(CosLimit)) begin
      c3_s = -CosLimit;
    end else begin
      c3_s = CosW'(dot3_sh);
    end
  end

  // distance key: quotient of 2**16 or more saturates
  assign ovfd = (DistW + QW)'(dist_s) >= ((DistW + QW)'(dstep) << QW);
  assign numd = ovfd ? '0 : dist_s;

  logic          v1, v2, vkd;
  logic [QW-1:0] q1, q2, qd;
  cos_tag_t      ct_v;
  logic          neg2_v, ovfd_v;

  ppfq_udiv #(.NW(DotW), .DW(DistW), .QW(QW), .TW($bits(cos_tag_t))) u_div_ref (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vs), .num_i(num1), .den_i(dist_s),
    .tag_i(ct_s), .valid_o(v1), .quot_o(q1), .tag_o(ct_v)
  );

  ppfq_udiv #(.NW(DotW), .DW(DistW), .QW(QW), .TW(1)) u_div_tgt (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vs), .num_i(num2), .den_i(dist_s),
    .tag_i(neg2), .valid_o(v2), .quot_o(q2), .tag_o(neg2_v)
  );

  ppfq_udiv #(.NW(DistW), .DW(DstW), .QW(QW), .TW(1)) u_div_dist (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vs), .num_i(numd), .den_i(dstep),
    .tag_i(ovfd), .valid_o(vkd), .quot_o(qd), .tag_o(ovfd_v)
  );

  // ---------------- clamp, sign, key setup ----------------
  typedef struct packed {
    logic signed [CosW-1:0] c1;
    logic signed [CosW-1:0] c2;
    logic signed [CosW-1:0] c3;
    logic [DistW-1:0]       dist_val;
    logic [KeyW-1:0]        kd;
    logic                   degen;
  } key_tag_t;

  logic [QW-1:0] m1, m2;
  key_tag_t      kt;
  logic [KeyW-1:0] kn1, kn2, kn3;

  assign m1 = (ct_v.ovf1 || q1 > QW'(CosLimit)) ? QW'(CosLimit) : q1;
  assign m2 = (ct_v.ovf2 || q2 > QW'(CosLimit)) ? QW'(CosLimit) : q2;

  assign kt.c1       = ct_v.degen ? '0 : (ct_v.neg1 ? -CosW'(m1) : CosW'(m1));
  assign kt.c2       = ct_v.degen ? '0 : (neg2_v ? -CosW'(m2) : CosW'(m2));
  assign kt.c3       = ct_v.degen ? '0 : ct_v.c3;
  assign kt.dist_val = ct_v.degen ? '0 : ct_v.dist_val;
  assign kt.kd       = ct_v.degen ? '0 : (ovfd_v ? KeyDistMax : qd);
  assign kt.degen    = ct_v.degen;

  // floor of a negative c over a: -((|c| + a - 1) / a)
  function automatic logic [KeyW-1:0] key_num(logic signed [CosW-1:0] c,
                                              logic [AngW-1:0] a);
    logic [KeyW-1:0] mag;
    mag = c[CosW-1] ? KeyW'(-c) : KeyW'(c);
    return c[CosW-1] ? KeyW'(mag + KeyW'(a) - KeyW'(1)) : mag;
  endfunction

  assign kn1 = key_num(kt.c1, astep);
  assign kn2 = key_num(kt.c2, astep);
  assign kn3 = key_num(kt.c3, astep);

  logic            vk1, vk2, vk3;
  logic [KeyW-1:0] kq1, kq2, kq3;
  key_tag_t        kt_v;
  logic            unused_a, unused_b;

  ppfq_udiv #(.NW(KeyW), .DW(AngW), .QW(KeyW), .TW($bits(key_tag_t))) u_key_ref (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v1 & v2 & vkd), .num_i(kn1),
    .den_i(astep), .tag_i(kt), .valid_o(vk1), .quot_o(kq1), .tag_o(kt_v)
  );

  ppfq_udiv #(.NW(KeyW), .DW(AngW), .QW(KeyW), .TW(1)) u_key_tgt (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v1 & v2 & vkd), .num_i(kn2),
    .den_i(astep), .tag_i(1'b0), .valid_o(vk2), .quot_o(kq2), .tag_o(unused_a)
  );

  ppfq_udiv #(.NW(KeyW), .DW(AngW), .QW(KeyW), .TW(1)) u_key_nrm (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v1 & v2 & vkd), .num_i(kn3),
    .den_i(astep), .tag_i(1'b0), .valid_o(vk3), .quot_o(kq3), .tag_o(unused_b)
  );

  // ---------------- output register ----------------
  logic     done_q;
  ppf_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vk1 & vk2 & vk3 & ~(unused_a | unused_b);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.cos_ref_dir   <= kt_v.c1;
    res_q.cos_tgt_dir   <= kt_v.c2;
    res_q.cos_normals   <= kt_v.c3;
    res_q.pair_distance <= kt_v.dist_val;
    res_q.key_ref_dir   <= kt_v.c1[CosW-1] ? -KeyW'(kq1) : KeyW'(kq1);
    res_q.key_tgt_dir   <= kt_v.c2[CosW-1] ? -KeyW'(kq2) : KeyW'(kq2);
    res_q.key_normals   <= kt_v.c3[CosW-1] ? -KeyW'(kq3) : KeyW'(kq3);
    res_q.key_distance  <= kt_v.kd;
    res_q.degenerate    <= kt_v.degen;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.degenerate |->
      res_o.pair_distance == '0 && res_o.key_distance == '0 && res_o.cos_normals == '0)
    else $error("degenerate pair with nonzero features");

  a_dist_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.degenerate |-> res_o.pair_distance != '0)
    else $error("distinct points gave zero distance");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.cos_ref_dir <= CosLimit && res_o.cos_ref_dir >= -CosLimit &&
               res_o.cos_tgt_dir <= CosLimit && res_o.cos_tgt_dir >= -CosLimit)
    else $error("cosine outside clamp range");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1 == v2) && (v1 == vkd) && (vk1 == vk2) && (vk1 == vk3))
    else $error("divider lanes out of step");
`endif

endmodule

// ----- bench/tb_point_pair_feature_quantizer.sv -----
`timescale 1ns / 1ps

module tb_point_pair_feature_quantizer;
  import ppfq_pkg::*;

  // Predicts the feature and key fields of one point pair under the current steps.
  class ppf_scoreboard;
    ppf_res_t pending_q[$];
    int unsigned mismatches;
    longint unsigned ang_step;
    longint unsigned dst_step;

    function new();
      ang_step = 1638;
      dst_step = 4096;
    endfunction

    static function longint isqrt(longint unsigned x);
      longint unsigned r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
      end
      return longint'(r);
    endfunction

    static function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    static function longint clampc(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
    endfunction

    function void note_request(ppf_req_t r);
      ppf_res_t e;
      longint dx, dy, dz, sq, dist_v, d1, d2, d3, as_, ds_, kd, k1, k2, k3;
      e = '0;
      dx = longint'(r.tgt_x) - longint'(r.ref_x);
      dy = longint'(r.tgt_y) - longint'(r.ref_y);
      dz = longint'(r.tgt_z) - longint'(r.ref_z);
      sq = dx * dx + dy * dy + dz * dz;
      as_ = (ang_step == 0) ? 1 : longint'(ang_step);
      ds_ = (dst_step == 0) ? 1 : longint'(dst_step);
      if (sq == 0) begin
        e.degenerate = 1'b1;
      end else begin
        d1 = longint'(r.ref_nx) * dx + longint'(r.ref_ny) * dy + longint'(r.ref_nz) * dz;
        d2 = longint'(r.tgt_nx) * dx + longint'(r.tgt_ny) * dy + longint'(r.tgt_nz) * dz;
        d3 = longint'(r.ref_nx) * r.tgt_nx + longint'(r.ref_ny) * r.tgt_ny
           + longint'(r.ref_nz) * r.tgt_nz;
        dist_v = isqrt(sq);
        d1 = clampc(d1 / dist_v);  // truncating division
        d2 = clampc(d2 / dist_v);
        d3 = clampc(fdiv(d3, 16384));
        e.cos_ref_dir = d1[15:0];
        e.cos_tgt_dir = d2[15:0];
        e.cos_normals = d3[15:0];
        e.pair_distance = dist_v[DistW-1:0];
        k1 = fdiv(d1, as_);
        k2 = fdiv(d2, as_);
        k3 = fdiv(d3, as_);
        e.key_ref_dir = k1[15:0];
        e.key_tgt_dir = k2[15:0];
        e.key_normals = k3[15:0];
        kd = dist_v / ds_;
        if (kd > 65535) kd = 65535;
        e.key_distance = kd[15:0];
      end
      pending_q = {pending_q, e};
    endfunction

    function void check_result(ppf_res_t got);
      ppf_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp c=%0d/%0d/%0d dist=%0d k=%0d/%0d/%0d/%0d dg=%0b",
                   e.cos_ref_dir, e.cos_tgt_dir, e.cos_normals, e.pair_distance,
                   e.key_ref_dir, e.key_tgt_dir, e.key_normals, e.key_distance,
                   e.degenerate);
          $display("          got c=%0d/%0d/%0d dist=%0d k=%0d/%0d/%0d/%0d dg=%0b",
                   got.cos_ref_dir, got.cos_tgt_dir, got.cos_normals, got.pair_distance,
                   got.key_ref_dir, got.key_tgt_dir, got.key_normals, got.key_distance,
                   got.degenerate);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  ppf_req_t    req_i;
  logic        done_o;
  ppf_res_t    res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ppf_scoreboard sb;
  int unsigned   idle_pct;

  point_pair_feature_quantizer DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // APB write with setup and access phases; register index sits at paddr[2]
  task automatic write_step(input logic idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegAngleStep) sb.ang_step = 64'(val[14:0]);
    else sb.dst_step = 64'(val[23:0]);
  endtask

  // send one request, holding start until the block takes it
  task automatic send_pair(input ppf_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // wait for all pending results, then the pipeline depth for stragglers
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_pos(int mode);
    case (mode)
      0: return 24'($urandom);                             // full range
      1: return 24'($urandom_range(8191) - 4096);          // tiny offsets
      default: return 24'($urandom_range(1 << 20) - (1 << 19));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_nrm();
    if ($urandom_range(9) == 0) return 16'($urandom);      // out of unit range
    return 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic ppf_req_t rand_pair();
    ppf_req_t r;
    int m;
    m = int'($urandom_range(2));
    r.ref_x = rand_pos(m); r.ref_y = rand_pos(m); r.ref_z = rand_pos(m);
    r.ref_nx = rand_nrm(); r.ref_ny = rand_nrm(); r.ref_nz = rand_nrm();
    if ($urandom_range(15) == 0) begin
      r.tgt_x = r.ref_x; r.tgt_y = r.ref_y; r.tgt_z = r.ref_z;   // coincident
    end else if (m == 0) begin
      r.tgt_x = rand_pos(0); r.tgt_y = rand_pos(0); r.tgt_z = rand_pos(0);
    end else begin
      r.tgt_x = r.ref_x + rand_pos(m);
      r.tgt_y = r.ref_y + rand_pos(m);
      r.tgt_z = r.ref_z + rand_pos(m);
    end
    r.tgt_nx = rand_nrm(); r.tgt_ny = rand_nrm(); r.tgt_nz = rand_nrm();
    return r;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_pair());
  endtask

  initial begin
    ppf_req_t r;
    sb = new();
    idle_pct = 0;
    rst_ni = 1'b0; start_i = 1'b0; req_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, coincident points, unit axes, oversized normals
    r = '0;
    send_pair(r);                                      // coincident at origin
    r.ref_x = 24'sh800000; r.ref_y = 24'sh800000; r.ref_z = 24'sh800000;
    r.tgt_x = 24'sh7FFFFF; r.tgt_y = 24'sh7FFFFF; r.tgt_z = 24'sh7FFFFF;
    r.ref_nx = 16'sd16384; r.tgt_nx = -16'sd16384;
    send_pair(r);                                      // longest distance
    r.ref_x = 24'sh7FFFFF; r.tgt_x = 24'sh800000;
    r.ref_y = 0; r.tgt_y = 0; r.ref_z = 0; r.tgt_z = 0;
    send_pair(r);
    r = '0; r.tgt_x = 24'sd1; r.ref_nx = 16'sd16384; r.tgt_nx = 16'sd16384;
    send_pair(r);                                      // unit step, aligned normals
    r.ref_nx = 16'sh7FFF; r.ref_ny = 16'sh7FFF; r.ref_nz = 16'sh7FFF;
    r.tgt_nx = 16'sh8000; r.tgt_ny = 16'sh8000; r.tgt_nz = 16'sh8000;
    send_pair(r);                                      // normals far outside unit range
    r.tgt_x = -24'sd1; r.tgt_y = 24'sd1; r.tgt_z = -24'sd1;
    send_pair(r);
    r.ref_nx = 16'hFFFF; r.ref_ny = 16'hFFFF; r.ref_nz = 16'hFFFF;
    r.tgt_nx = 16'hFFFF; r.tgt_ny = 16'hFFFF; r.tgt_nz = 16'hFFFF;
    r.ref_x = 24'hFFFFFF; r.ref_y = 24'hFFFFFF; r.ref_z = 24'hFFFFFF;
    send_pair(r);
    r = '0; r.ref_y = 24'sd4096; r.ref_ny = -16'sd16384; r.tgt_nz = 16'sd16384;
    send_pair(r);
    drain();

    // zero steps behave as one
    write_step(RegAngleStep, 32'd0);
    write_step(RegDistStep, 32'd0);
    for (int i = 0; i < 8; i++) send_pair(rand_pair());
    drain();

    idle_pct = 18;
    write_step(RegAngleStep, 32'd16384);
    write_step(RegDistStep, 32'hFFFFFFFF);             // upper bits dropped
    random_phase(130);
    drain();                                           // sender waits for all results

    idle_pct = 84;
    write_step(RegAngleStep, 32'd1);
    write_step(RegDistStep, 32'd1);
    random_phase(130);
    drain();

    idle_pct = 0;
    write_step(RegAngleStep, $urandom_range(32767));
    write_step(RegDistStep, $urandom_range(65535));
    random_phase(130);
    drain();
    write_step(RegAngleStep, 32'd1638);
    write_step(RegDistStep, 32'd4096);
    random_phase(100);
    drain();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ppfq_pkg.sv
design/ppfq_udiv.sv
design/ppfq_isqrt.sv
design/point_pair_feature_quantizer.sv
bench/tb_point_pair_feature_quantizer.sv
